@@ hw/rtl/sfd_pkg.sv @@
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int unsigned FIELD_W      = 64;
	localparam int unsigned IN_TDATA_W   = 2 * FIELD_W;
	localparam int unsigned OUT_TDATA_W  = 2 * FIELD_W;
	localparam int unsigned OUT_TUSER_W  = 2;

	// tuser bit positions on the result side
	localparam int unsigned TUSER_DZ_BIT = 0;
	localparam int unsigned TUSER_OV_BIT = 1;

	typedef struct packed {
		logic valid;
		logic neg_a;
		logic neg_b;
		logic dz;
		logic ov;
	} ctl_t;

endpackage

@@ hw/rtl/sfd_cell.sv @@
`timescale 1ns / 1ps

module sfd_cell #(
	parameter int unsigned W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  sfd_pkg::ctl_t       ctl_in,
	input  logic [W-1:0]        rem_in,
	input  logic [W-1:0]        aq_in,
	input  logic [W-1:0]        mb_in,
	output sfd_pkg::ctl_t       ctl_q,
	output logic [W-1:0]        rem_q,
	output logic [W-1:0]        aq_q,
	output logic [W-1:0]        mb_q
);

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_next;
	logic [W-1:0] aq_next;

	// bring down the next dividend bit and try one subtraction
	assign trial    = {rem_in, aq_in[W-1]};
	assign diff     = trial - {1'b0, mb_in};
	assign ge       = trial >= {1'b0, mb_in};
	assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];
	assign aq_next  = {aq_in[W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_q <= rem_next;
			aq_q  <= aq_next;
			mb_q  <= mb_in;
		end
	end

endmodule

@@ hw/rtl/signed_floor_divider_core.sv @@
`timescale 1ns / 1ps

// Signed floor divider: one dividend/divisor pair is accepted per clock unless
// the result side stalls, and each passes through one input stage that takes
// magnitudes, DATA_WIDTH restoring-division cells that each resolve one
// quotient bit, and one output stage that applies signs and floor correction.
// The quotient rounds toward negative infinity and the remainder carries the
// divisor's sign. A zero divisor sets divide_by_zero with quotient 0 and
// remainder equal to the dividend; the most negative dividend over -1 sets
// overflow with the largest positive quotient and remainder 0. Only the low
// DATA_WIDTH bits of each operand are used; results are sign-extended to 64 bits.
// A stall on the result side holds the whole chain.
module signed_floor_divider_core #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [63:0] dividend, [127:64] divisor
	input  logic [sfd_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] quotient, [127:64] remainder
	output logic [sfd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// [0] divide_by_zero, [1] overflow
	output logic [sfd_pkg::OUT_TUSER_W-1:0]     m_tuser
);

	localparam int unsigned W = DATA_WIDTH;
	localparam int unsigned FW = sfd_pkg::FIELD_W;

	logic advance;

	// input stage
	logic [W-1:0]  a_in;
	logic [W-1:0]  b_in;
	sfd_pkg::ctl_t ctl_pre;
	logic [W-1:0]  ma_pre;
	logic [W-1:0]  mb_pre;

	sfd_pkg::ctl_t ctl_s1;
	logic [W-1:0]  ma_s1;
	logic [W-1:0]  mb_s1;

	// cell chain taps
	sfd_pkg::ctl_t ctl_c [0:W];
	logic [W-1:0]  rem_c [0:W];
	logic [W-1:0]  aq_c  [0:W];
	logic [W-1:0]  mb_c  [0:W];

	// output stage
	sfd_pkg::ctl_t ctl_l;
	logic [W-1:0]  qm;
	logic [W-1:0]  rm;
	logic [W-1:0]  mb_l;
	logic          neg;
	logic          fix;
	logic [W-1:0]  q_next;
	logic [W-1:0]  r_next;

	sfd_pkg::ctl_t ctl_out_q;
	logic [W-1:0]  quotient_q;
	logic [W-1:0]  remainder_q;

	assign advance  = !ctl_out_q.valid || m_tready;
	assign s_tready = advance;

	assign a_in = s_tdata[W-1:0];
	assign b_in = s_tdata[FW +: W];

	always_comb begin
		ctl_pre.valid = s_tvalid;
		ctl_pre.neg_a = a_in[W-1];
		ctl_pre.neg_b = b_in[W-1];
		ctl_pre.dz    = (b_in == '0);
		ctl_pre.ov    = (a_in == {1'b1, {(W-1){1'b0}}}) && (&b_in);
		ma_pre        = a_in[W-1] ? (~a_in + 1'b1) : a_in;
		mb_pre        = b_in[W-1] ? (~b_in + 1'b1) : b_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_pre;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ma_s1 <= ma_pre;
			mb_s1 <= mb_pre;
		end
	end

	assign ctl_c[0] = ctl_s1;
	assign rem_c[0] = '0;
	assign aq_c[0]  = ma_s1;
	assign mb_c[0]  = mb_s1;

	for (genvar i = 0; i < W; i++) begin : g_cell
		sfd_cell #(
			.W(W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.ctl_in (ctl_c[i]),
			.rem_in (rem_c[i]),
			.aq_in  (aq_c[i]),
			.mb_in  (mb_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.aq_q   (aq_c[i+1]),
			.mb_q   (mb_c[i+1])
		);
	end

	assign ctl_l = ctl_c[W];
	assign qm    = aq_c[W];
	assign rm    = rem_c[W];
	assign mb_l  = mb_c[W];

	// -qm - 1 is ~qm, so the floor step folds into the sign flip
	always_comb begin
		neg = ctl_l.neg_a ^ ctl_l.neg_b;
		fix = neg && (rm != '0);
		if (ctl_l.dz) begin
			q_next = '0;
		end else if (ctl_l.ov) begin
			q_next = {1'b0, {(W-1){1'b1}}};
		end else if (!neg) begin
			q_next = qm;
		end else if (fix) begin
			q_next = ~qm;
		end else begin
			q_next = ~qm + 1'b1;
		end

		if (ctl_l.ov) begin
			r_next = '0;
		end else if (fix) begin
			r_next = ctl_l.neg_a ? (mb_l - rm) : (rm - mb_l);
		end else if (ctl_l.neg_a) begin
			r_next = ~rm + 1'b1;
		end else begin
			r_next = rm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out_q <= '0;
		end else if (advance) begin
			ctl_out_q <= ctl_l;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quotient_q  <= q_next;
			remainder_q <= r_next;
		end
	end

	assign m_tvalid = ctl_out_q.valid;
	assign m_tdata  = {FW'(signed'(remainder_q)), FW'(signed'(quotient_q))};
	always_comb begin
		m_tuser                        = '0;
		m_tuser[sfd_pkg::TUSER_DZ_BIT] = ctl_out_q.dz;
		m_tuser[sfd_pkg::TUSER_OV_BIT] = ctl_out_q.ov;
	end

endmodule

@@ hw/rtl/sfd_checker.sv @@
`timescale 1ns / 1ps

module sfd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [sfd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input logic [sfd_pkg::OUT_TUSER_W-1:0]     m_tuser
);

	localparam int unsigned FW = sfd_pkg::FIELD_W;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// the chain never stalls the input while the result side is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[sfd_pkg::TUSER_DZ_BIT] && m_tuser[sfd_pkg::TUSER_OV_BIT]))
		else $error("both flags set");

	a_dz_q: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[sfd_pkg::TUSER_DZ_BIT] |-> m_tdata[FW-1:0] == '0)
		else $error("nonzero quotient on zero divisor");

	a_ov_r: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[sfd_pkg::TUSER_OV_BIT] |-> m_tdata[2*FW-1:FW] == '0)
		else $error("nonzero remainder on overflow");

endmodule

bind signed_floor_divider_core sfd_checker u_sfd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int DW = 64;
	localparam int PIPE_LAT = DW + 2;
	localparam int PAIRS_PER_PHASE = 182;
	localparam logic [63:0] DW_MASK = {64{1'b1}} >> (64 - DW);
	localparam logic [63:0] MOST_NEG = ~(DW_MASK >> 1);
	localparam logic [63:0] MOST_POS = DW_MASK >> 1;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG1 = {64{1'b1}};

	typedef struct packed {
		logic [63:0] quo;
		logic [63:0] rem;
		logic        dz;
		logic        ov;
	} div_result_t;

	typedef struct packed {
		logic [63:0] dividend;
		logic [63:0] divisor;
		logic        known;
		div_result_t want;
	} stim_row_t;

	// operands, then whether the result is typed in here or left to the predictor
	localparam int N_DIRECTED = 23;
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{64'd0,          64'd0,        1'b1, '{64'd0,        64'd0,       1'b1, 1'b0}},
		'{64'd7,          64'd0,        1'b1, '{64'd0,        64'd7,       1'b1, 1'b0}},
		'{MIN64,          64'd0,        1'b1, '{64'd0,        MIN64,       1'b1, 1'b0}},
		'{MAX64,          64'd0,        1'b1, '{64'd0,        MAX64,       1'b1, 1'b0}},
		'{MIN64,          NEG1,         1'b1, '{MAX64,        64'd0,       1'b0, 1'b1}},
		'{MAX64,          64'd1,        1'b1, '{MAX64,        64'd0,       1'b0, 1'b0}},
		'{MIN64,          64'd1,        1'b1, '{MIN64,        64'd0,       1'b0, 1'b0}},
		'{MAX64,          NEG1,         1'b1, '{MIN64 + 1,    64'd0,       1'b0, 1'b0}},
		'{MIN64,          MIN64,        1'b1, '{64'd1,        64'd0,       1'b0, 1'b0}},
		'{MAX64,          MIN64,        1'b1, '{NEG1,         NEG1,        1'b0, 1'b0}},
		'{MIN64,          MAX64,        1'b1, '{-64'sd2,      MAX64 - 1,   1'b0, 1'b0}},
		'{NEG1,           MIN64,        1'b1, '{64'd0,        NEG1,        1'b0, 1'b0}},
		'{64'd1,          MIN64,        1'b1, '{NEG1,         MIN64 + 1,   1'b0, 1'b0}},
		'{64'd7,          64'd2,        1'b1, '{64'd3,        64'd1,       1'b0, 1'b0}},
		'{-64'sd7,        64'd2,        1'b1, '{-64'sd4,      64'd1,       1'b0, 1'b0}},
		'{64'd7,          -64'sd2,      1'b1, '{-64'sd4,      NEG1,        1'b0, 1'b0}},
		'{-64'sd7,        -64'sd2,      1'b1, '{64'd3,        NEG1,        1'b0, 1'b0}},
		'{-64'sd6,        64'd3,        1'b1, '{-64'sd2,      64'd0,       1'b0, 1'b0}},
		'{MIN64,          -64'sd2,      1'b1, '{64'h4000_0000_0000_0000, 64'd0, 1'b0, 1'b0}},
		'{NEG1,           MAX64,        1'b1, '{NEG1,         MAX64 - 1,   1'b0, 1'b0}},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_5555_5555, 1'b0, '0},
		'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{64'hFFFF_FFFF_0000_0001, 64'd3,                   1'b0, '0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [sfd_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [sfd_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [sfd_pkg::OUT_TUSER_W-1:0] m_tuser;

	div_result_t pending_results [$];
	int src_idle_pct;
	int sink_stall_pct;
	int error_count;
	int pairs_sent;
	int results_checked;
	int dz_seen;
	int ov_seen;

	signed_floor_divider_core #(
		.DATA_WIDTH(DW)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	function automatic logic [63:0] sext_dw(logic [63:0] raw);
		logic [63:0] x;
		x = raw & DW_MASK;
		if (x[DW-1]) begin
			x |= ~DW_MASK;
		end
		return x;
	endfunction

	// floor quotient, remainder with the divisor's sign, both special cases flagged
	function automatic div_result_t floor_divide(logic [63:0] dividend_raw,
		logic [63:0] divisor_raw);
		logic [63:0] a, b, ma, mb, qm, rm;
		logic neg_a, neg_b;
		div_result_t res;
		a = sext_dw(dividend_raw);
		b = sext_dw(divisor_raw);
		neg_a = a[63];
		neg_b = b[63];
		res = '0;
		if (b == 64'd0) begin
			res.rem = a;
			res.dz = 1'b1;
		end else if (a == MOST_NEG && b == NEG1) begin
			res.quo = MOST_POS;
			res.ov = 1'b1;
		end else begin
			ma = neg_a ? 64'd0 - a : a;
			mb = neg_b ? 64'd0 - b : b;
			qm = ma / mb;
			rm = ma % mb;
			res.quo = (neg_a != neg_b) ? 64'd0 - qm : qm;
			res.rem = neg_a ? 64'd0 - rm : rm;
			if (rm != 64'd0 && neg_a != neg_b) begin
				res.quo -= 64'd1;
				res.rem += b;
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] pick_operand();
		int unsigned k;
		logic [63:0] v;
		k = $urandom_range(9);
		case (k)
			0, 1, 2, 3: v = {$urandom, $urandom};
			4: v = 64'(longint'($urandom_range(200)) - 64'sd100);
			5: begin
				case ($urandom_range(4))
					0: v = MIN64;
					1: v = MAX64;
					2: v = NEG1;
					3: v = 64'd0;
					default: v = 64'd1;
				endcase
			end
			6: begin
				v = (64'd1 << $urandom_range(63)) + 64'(longint'($urandom_range(2)) - 64'sd1);
			end
			default: v = {$urandom, $urandom} >> $urandom_range(63);
		endcase
		if (k >= 6 && $urandom_range(1) == 1) begin
			v = 64'd0 - v;
		end
		return v;
	endfunction

	// drive one pair, wait for its transaction, and record what must come back
	task automatic send_pair(input logic [63:0] dividend, input logic [63:0] divisor,
		input logic known, input div_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom, $urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {divisor, dividend};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(known ? want : floor_divide(dividend, divisor));
		pairs_sent++;
	endtask

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, field,
			$signed(want), $signed(got));
		error_count++;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_results
		div_result_t got;
		div_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[63:0], m_tdata[127:64], m_tuser[sfd_pkg::TUSER_DZ_BIT],
				m_tuser[sfd_pkg::TUSER_OV_BIT]};
			dz_seen += got.dz;
			ov_seen += got.ov;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: quotient %0d, remainder %0d",
					$time, $signed(got.quo), $signed(got.rem));
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.quo !== want.quo) report("quotient", want.quo, got.quo);
				if (got.rem !== want.rem) report("remainder", want.rem, got.rem);
				if (got.dz !== want.dz) report("divide_by_zero", 64'(want.dz), 64'(got.dz));
				if (got.ov !== want.ov) report("overflow", 64'(want.ov), 64'(got.ov));
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int src_pct [4];
		int sink_pct [4];
		logic [63:0] a, b;
		src_pct = '{0, 77, 0, 38};
		sink_pct = '{0, 0, 77, 38};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		error_count = 0;
		pairs_sent = 0;
		results_checked = 0;
		dz_seen = 0;
		ov_seen = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_pair(directed_rows[i].dividend, directed_rows[i].divisor,
				directed_rows[i].known, directed_rows[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			// hold the input until the pipeline has drained completely
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
			src_idle_pct = src_pct[phase];
			sink_stall_pct = sink_pct[phase];
			for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
				a = pick_operand();
				b = pick_operand();
				case ($urandom_range(24))
					0: b = 64'd0;
					1: begin
						a = MIN64;
						b = NEG1;
					end
					default: ;
				endcase
				send_pair(a, b, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		sink_stall_pct = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3 * PIPE_LAT) @(posedge clk);

		$display("Sent %0d dividend/divisor pairs (%0d directed) under four idle/stall mixes;",
			pairs_sent, N_DIRECTED);
		$display("checked %0d results, %0d with divide-by-zero and %0d with overflow.",
			results_checked, dz_seen, ov_seen);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_cell.sv
hw/rtl/signed_floor_divider_core.sv
hw/rtl/sfd_checker.sv
bench/testbench.sv
